// ----- hw/rtl/qrs_pkg.sv -----
// Package with the widths, types and codes shared by the quadratic root solver files.
package qrs_pkg;

    localparam int COEF_W    = 16;
    localparam int ROOT_W    = 32;
    localparam int ROOT_FRAC = ROOT_W / 2;
    localparam int SQRT_FRAC = ROOT_FRAC - 1;

    // Products, discriminant and its magnitude.
    localparam int PROD_W = 2 * COEF_W;
    localparam int DISC_W = 2 * COEF_W + 3;
    localparam int MAG_W  = 2 * COEF_W + 2;

    // Square root: one result bit per stage over an even-width radicand.
    localparam int SQ_STEPS = (MAG_W + 2 * SQRT_FRAC + 1) / 2;
    localparam int SQ_IN_W  = 2 * SQ_STEPS;
    localparam int SQ_REM_W = SQ_STEPS + 2;

    // Numerators and divider: one quotient bit per stage.
    localparam int SR_W   = SQ_STEPS + (ROOT_FRAC - SQRT_FRAC);
    localparam int NB_W   = COEF_W + ROOT_FRAC + 1;
    localparam int NUM_W  = ((SR_W + 1 > NB_W) ? SR_W + 1 : NB_W) + 1;
    localparam int DEN_W  = COEF_W + 1;
    localparam int CMP_W  = ((NUM_W > ROOT_W) ? NUM_W : ROOT_W) + 1;

    // Register stages: two front stages, the root, the numerators, the divide, the output.
    localparam int NSTG = SQ_STEPS + NUM_W + 4;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_A_ZERO = 2'd1,
        ST_SAT    = 2'd2
    } t_status;

    typedef struct packed {
        logic [COEF_W-1:0] a;
        logic [COEF_W-1:0] b;
        logic              cplx;
        logic              a_zero;
    } t_sq_side;

    typedef struct packed {
        logic [DEN_W-1:0] den;
        logic             neg1;
        logic             neg2;
        logic             cplx;
        logic             a_zero;
    } t_dv_side;

    typedef struct packed {
        logic [ROOT_W-1:0] v;
        logic              sat;
    } t_part;

    typedef struct packed {
        logic [ROOT_W-1:0] root1_real;
        logic [ROOT_W-1:0] root1_imag;
        logic [ROOT_W-1:0] root2_real;
        logic [ROOT_W-1:0] root2_imag;
        logic              roots_complex;
        t_status           status;
    } t_res;

endpackage

// ----- hw/rtl/qrs_in_if.sv -----
// Coefficient channel: valid, ready and the three coefficients.
interface qrs_in_if;
    import qrs_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [COEF_W-1:0] coef_c;

    modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
    modport sink   (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

// ----- hw/rtl/qrs_out_if.sv -----
// Root channel: valid, ready and the roots with their flags.
interface qrs_out_if;
    import qrs_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [ROOT_W-1:0] root1_real;
    logic signed [ROOT_W-1:0] root1_imag;
    logic signed [ROOT_W-1:0] root2_real;
    logic signed [ROOT_W-1:0] root2_imag;
    logic                     roots_complex;
    logic [1:0]               status;

    modport source (output valid, output root1_real, output root1_imag, output root2_real,
                    output root2_imag, output roots_complex, output status, input ready);
    modport sink   (input valid, input root1_real, input root1_imag, input root2_real,
                    input root2_imag, input roots_complex, input status, output ready);
endinterface

// ----- hw/rtl/quadratic_root_solver_unit.sv -----
// The root word reaches the output through NSTG register stages, the first loaded at the
// accepting edge: two front stages, one per square root bit, one numerator stage,
// one per quotient bit, output.
// Throughput: one coefficient word per cycle; the whole pipe holds while a finished
// root word waits at the output register.
// Reset clears every stage valid bit; the data registers are not reset.
module quadratic_root_solver_unit (
    input logic   i_clk,
    input logic   i_rst_n,
    qrs_in_if.sink    i_coef,
    qrs_out_if.source o_root
);
    import qrs_pkg::*;

    logic [NSTG-1:0] r_vld;
    logic            w_adv;

    // Front stages.
    logic signed [PROD_W-1:0] w_bb, w_ac;
    logic signed [PROD_W-1:0] r_bb, r_ac;
    logic [COEF_W-1:0]        r_s1_a, r_s1_b;
    logic                     r_s1_az;
    logic signed [DISC_W-1:0] w_disc;
    logic                     w_cplx;
    logic [DISC_W-1:0]        w_mag_full;

    // Square root pipe, index 0 is the radicand stage.
    logic [SQ_IN_W-1:0]  r_sq_x    [0:SQ_STEPS];
    logic [SQ_REM_W-1:0] r_sq_rem  [0:SQ_STEPS];
    logic [SQ_STEPS-1:0] r_sq_root [0:SQ_STEPS];
    t_sq_side            r_sq_sd   [0:SQ_STEPS];
    logic [SQ_IN_W-1:0]  n_sq_x    [1:SQ_STEPS];
    logic [SQ_REM_W-1:0] n_sq_rem  [1:SQ_STEPS];
    logic [SQ_STEPS-1:0] n_sq_root [1:SQ_STEPS];
    logic [SQ_REM_W+1:0] w_sq_t    [1:SQ_STEPS];
    logic [SQ_REM_W+1:0] w_sq_trl  [1:SQ_STEPS];

    // Numerator stage.
    t_sq_side                w_ns;
    logic signed [NUM_W-1:0] w_sr, w_nb, w_num1, w_num2;
    logic [NUM_W-1:0]        w_mag1, w_mag2;
    logic [DEN_W-1:0]        w_aext, w_amag;
    t_dv_side                w_dsd;

    // Divide pipe, two lanes, index 0 is the numerator stage.
    logic [NUM_W-1:0] r_dv_w   [0:1][0:NUM_W];
    logic [DEN_W-1:0] r_dv_rem [0:1][0:NUM_W];
    t_dv_side         r_dv_sd  [0:NUM_W];
    logic [NUM_W-1:0] n_dv_w   [0:1][1:NUM_W];
    logic [DEN_W-1:0] n_dv_rem [0:1][1:NUM_W];
    logic [DEN_W:0]   w_dv_t   [0:1][1:NUM_W];

    // Output stage.
    t_dv_side w_os;
    t_part    w_p1, w_p2, w_p3;
    t_res     n_out, r_out;

    function automatic t_part sat_q(input logic [NUM_W-1:0] q, input logic neg);
        logic [CMP_W-1:0] qe;
        logic [CMP_W-1:0] lim;
        t_part            p;
        qe  = CMP_W'(q);
        lim = CMP_W'({1'b0, {(ROOT_W-1){1'b1}}});
        p.sat = 1'b0;
        p.v   = '0;
        if (!neg) begin
            if (qe > lim) begin
                p.v   = {1'b0, {(ROOT_W-1){1'b1}}};
                p.sat = 1'b1;
            end else begin
                p.v = ROOT_W'(qe);
            end
        end else begin
            if (qe > lim + CMP_W'(1)) begin
                p.v   = {1'b1, {(ROOT_W-1){1'b0}}};
                p.sat = 1'b1;
            end else begin
                p.v = ROOT_W'(-qe);
            end
        end
        return p;
    endfunction

    // The pipe moves as a whole whenever the output register is free or being drained.
    assign w_adv        = !r_vld[NSTG-1] || o_root.ready;
    assign i_coef.ready = w_adv;

    assign w_bb = i_coef.coef_b * i_coef.coef_b;
    assign w_ac = i_coef.coef_a * i_coef.coef_c;

    always_comb begin
        w_disc     = DISC_W'(r_bb) - (DISC_W'(r_ac) <<< 2);
        w_cplx     = w_disc[DISC_W-1];
        w_mag_full = w_cplx ? DISC_W'(-w_disc) : DISC_W'(w_disc);
    end

    // One root bit per stage: bring down two radicand bits, try root*4+1.
    always_comb begin
        for (int k = 1; k <= SQ_STEPS; k++) begin
            w_sq_t[k]   = {r_sq_rem[k-1], r_sq_x[k-1][SQ_IN_W-1 -: 2]};
            w_sq_trl[k] = {2'b00, r_sq_root[k-1], 2'b01};
            n_sq_x[k]   = r_sq_x[k-1] << 2;
            if (w_sq_t[k] >= w_sq_trl[k]) begin
                n_sq_rem[k]  = SQ_REM_W'(w_sq_t[k] - w_sq_trl[k]);
                n_sq_root[k] = {r_sq_root[k-1][SQ_STEPS-2:0], 1'b1};
            end else begin
                n_sq_rem[k]  = SQ_REM_W'(w_sq_t[k]);
                n_sq_root[k] = {r_sq_root[k-1][SQ_STEPS-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        w_ns   = r_sq_sd[SQ_STEPS];
        w_sr   = NUM_W'(r_sq_root[SQ_STEPS]) << (ROOT_FRAC - SQRT_FRAC);
        w_nb   = -(NUM_W'($signed(w_ns.b)) <<< ROOT_FRAC);
        w_num1 = w_ns.cplx ? w_nb : w_nb + w_sr;
        w_num2 = w_ns.cplx ? w_sr : w_nb - w_sr;
        w_mag1 = w_num1[NUM_W-1] ? NUM_W'(-w_num1) : NUM_W'(w_num1);
        w_mag2 = w_num2[NUM_W-1] ? NUM_W'(-w_num2) : NUM_W'(w_num2);
        w_aext = DEN_W'($signed(w_ns.a));
        w_amag = w_ns.a[COEF_W-1] ? DEN_W'(-w_aext) : w_aext;
        w_dsd.den    = w_amag << 1;
        w_dsd.neg1   = w_num1[NUM_W-1] ^ w_ns.a[COEF_W-1];
        w_dsd.neg2   = w_num2[NUM_W-1] ^ w_ns.a[COEF_W-1];
        w_dsd.cplx   = w_ns.cplx;
        w_dsd.a_zero = w_ns.a_zero;
    end

    // Restoring division, one quotient bit per stage; quotient bits shift in from the right.
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            for (int k = 1; k <= NUM_W; k++) begin
                w_dv_t[l][k] = {r_dv_rem[l][k-1], r_dv_w[l][k-1][NUM_W-1]};
                if (w_dv_t[l][k] >= {1'b0, r_dv_sd[k-1].den}) begin
                    n_dv_rem[l][k] = DEN_W'(w_dv_t[l][k] - {1'b0, r_dv_sd[k-1].den});
                    n_dv_w[l][k]   = {r_dv_w[l][k-1][NUM_W-2:0], 1'b1};
                end else begin
                    n_dv_rem[l][k] = DEN_W'(w_dv_t[l][k]);
                    n_dv_w[l][k]   = {r_dv_w[l][k-1][NUM_W-2:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        w_os = r_dv_sd[NUM_W];
        w_p1 = sat_q(r_dv_w[0][NUM_W], w_os.neg1);
        w_p2 = sat_q(r_dv_w[1][NUM_W], w_os.neg2);
        w_p3 = sat_q(r_dv_w[1][NUM_W], !w_os.neg2);
        n_out.root1_real    = w_p1.v;
        n_out.roots_complex = w_os.cplx;
        if (w_os.cplx) begin
            n_out.root1_imag = w_p2.v;
            n_out.root2_real = w_p1.v;
            n_out.root2_imag = w_p3.v;
            n_out.status     = (w_p1.sat || w_p2.sat || w_p3.sat) ? ST_SAT : ST_OK;
        end else begin
            n_out.root1_imag = '0;
            n_out.root2_real = w_p2.v;
            n_out.root2_imag = '0;
            n_out.status     = (w_p1.sat || w_p2.sat) ? ST_SAT : ST_OK;
        end
        if (w_os.a_zero) begin
            n_out = '0;
            n_out.status = ST_A_ZERO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NSTG-2:0], i_coef.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_bb    <= w_bb;
            r_ac    <= w_ac;
            r_s1_a  <= i_coef.coef_a;
            r_s1_b  <= i_coef.coef_b;
            r_s1_az <= (i_coef.coef_a == '0);

            r_sq_x[0]         <= SQ_IN_W'(w_mag_full) << (2 * SQRT_FRAC);
            r_sq_rem[0]       <= '0;
            r_sq_root[0]      <= '0;
            r_sq_sd[0].a      <= r_s1_a;
            r_sq_sd[0].b      <= r_s1_b;
            r_sq_sd[0].cplx   <= w_cplx;
            r_sq_sd[0].a_zero <= r_s1_az;
            for (int k = 1; k <= SQ_STEPS; k++) begin
                r_sq_x[k]    <= n_sq_x[k];
                r_sq_rem[k]  <= n_sq_rem[k];
                r_sq_root[k] <= n_sq_root[k];
                r_sq_sd[k]   <= r_sq_sd[k-1];
            end

            r_dv_w[0][0]   <= w_mag1;
            r_dv_w[1][0]   <= w_mag2;
            r_dv_rem[0][0] <= '0;
            r_dv_rem[1][0] <= '0;
            r_dv_sd[0]     <= w_dsd;
            for (int k = 1; k <= NUM_W; k++) begin
                for (int l = 0; l < 2; l++) begin
                    r_dv_w[l][k]   <= n_dv_w[l][k];
                    r_dv_rem[l][k] <= n_dv_rem[l][k];
                end
                r_dv_sd[k] <= r_dv_sd[k-1];
            end

            r_out <= n_out;
        end
    end

    assign o_root.valid         = r_vld[NSTG-1];
    assign o_root.root1_real    = r_out.root1_real;
    assign o_root.root1_imag    = r_out.root1_imag;
    assign o_root.root2_real    = r_out.root2_real;
    assign o_root.root2_imag    = r_out.root2_imag;
    assign o_root.roots_complex = r_out.roots_complex;
    assign o_root.status        = r_out.status;

endmodule

// ----- hw/rtl/qrs_checker.sv -----
// Port checker for the quadratic root solver, bound to the top level.
module qrs_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_out_valid,
    input logic                                  i_out_ready,
    input logic [qrs_pkg::ROOT_W-1:0]            i_r1_re,
    input logic [qrs_pkg::ROOT_W-1:0]            i_r1_im,
    input logic [qrs_pkg::ROOT_W-1:0]            i_r2_re,
    input logic [qrs_pkg::ROOT_W-1:0]            i_r2_im,
    input logic                                  i_cplx,
    input logic [1:0]                            i_status
);
    import qrs_pkg::*;

    // A stalled word stays valid and keeps its real parts and status.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_r1_re) && $stable(i_r2_re)
        && $stable(i_status))
        else $error("root word changed while stalled");

    // A zero leading coefficient gives all-zero roots.
    a_azero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_A_ZERO |-> i_r1_re == '0 && i_r1_im == '0
        && i_r2_re == '0 && i_r2_im == '0 && !i_cplx)
        else $error("nonzero roots with a zero leading coefficient");

    // A conjugate pair shares its real part.
    a_cplx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_cplx |-> i_r1_re == i_r2_re && i_status != ST_A_ZERO)
        else $error("complex roots with different real parts");

    // Real roots have no imaginary part.
    a_real: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_cplx |-> i_r1_im == '0 && i_r2_im == '0)
        else $error("real roots with imaginary part");

endmodule

bind quadratic_root_solver_unit qrs_checker u_qrs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_root.valid),
    .i_out_ready (o_root.ready),
    .i_r1_re     (o_root.root1_real),
    .i_r1_im     (o_root.root1_imag),
    .i_r2_re     (o_root.root2_real),
    .i_r2_im     (o_root.root2_imag),
    .i_cplx      (o_root.roots_complex),
    .i_status    (o_root.status)
);

// ----- sim/qrs_checker.sv -----
// Checker for the quadratic root solver: predicts each root word and compares it.
`timescale 1ns / 1ps
module qrs_tb_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    qrs_in_if.sink     i_coef,
    qrs_out_if.sink    i_root,
    output int         o_fail_cnt,
    output int         o_pending
);
    import qrs_pkg::*;

    t_res roots_q[$];

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Truncating divide clamped to the root range; sets sat when clamped.
    function automatic logic [ROOT_W-1:0] clamp_div(longint num, longint den, inout logic sat);
        longint q;
        longint maxv;
        longint minv;
        maxv = (64'sd1 <<< (ROOT_W - 1)) - 1;
        minv = -maxv - 1;
        q = num / den;
        if (q > maxv) begin
            q = maxv;
            sat = 1'b1;
        end else if (q < minv) begin
            q = minv;
            sat = 1'b1;
        end
        return q[ROOT_W-1:0];
    endfunction

    function automatic t_res solve_roots(logic signed [COEF_W-1:0] ca,
                                         logic signed [COEF_W-1:0] cb,
                                         logic signed [COEF_W-1:0] cc);
        t_res r;
        longint a, b, c, disc, den, nb, sroot;
        longint unsigned mag;
        logic sat;
        a = ca;
        b = cb;
        c = cc;
        sat = 1'b0;
        r = '0;
        if (a == 0) begin
            r.status = ST_A_ZERO;
            return r;
        end
        disc = b * b - 4 * (a * c);
        r.roots_complex = disc < 0;
        mag = r.roots_complex ? longint'(-disc) : longint'(disc);
        sroot = int_sqrt(mag << (2 * SQRT_FRAC));
        sroot = sroot * (64'sd1 <<< (ROOT_FRAC - SQRT_FRAC));
        nb = -b * (64'sd1 <<< ROOT_FRAC);
        den = 2 * a;
        if (!r.roots_complex) begin
            r.root1_real = clamp_div(nb + sroot, den, sat);
            r.root2_real = clamp_div(nb - sroot, den, sat);
        end else begin
            r.root1_real = clamp_div(nb, den, sat);
            r.root1_imag = clamp_div(sroot, den, sat);
            r.root2_real = r.root1_real;
            r.root2_imag = clamp_div(-sroot, den, sat);
        end
        r.status = sat ? ST_SAT : ST_OK;
        return r;
    endfunction

    assign o_pending = roots_q.size();

    always @(posedge i_clk) begin
        t_res exp_r;
        t_res got;
        if (i_rst_n) begin
            if (i_coef.valid && i_coef.ready)
                roots_q.push_back(solve_roots(i_coef.coef_a, i_coef.coef_b, i_coef.coef_c));
            if (i_root.valid && i_root.ready) begin
                got.root1_real    = i_root.root1_real;
                got.root1_imag    = i_root.root1_imag;
                got.root2_real    = i_root.root2_real;
                got.root2_imag    = i_root.root2_imag;
                got.roots_complex = i_root.roots_complex;
                got.status        = t_status'(i_root.status);
                if (roots_q.size() == 0) begin
                    $display("%0t: root word with none expected: %h", $time, got);
                    o_fail_cnt <= o_fail_cnt + 1;
                end else begin
                    exp_r = roots_q.pop_front();
                    if (got.root1_real !== exp_r.root1_real || got.root1_imag !== exp_r.root1_imag
                        || got.root2_real !== exp_r.root2_real
                        || got.root2_imag !== exp_r.root2_imag
                        || got.roots_complex !== exp_r.roots_complex
                        || got.status !== exp_r.status) begin
                        $display("%0t: mismatch r1 %h+%hi r2 %h+%hi cplx %b st %0d",
                                 $time, exp_r.root1_real, exp_r.root1_imag, exp_r.root2_real,
                                 exp_r.root2_imag, exp_r.roots_complex, exp_r.status);
                        $display("%0t:   actual r1 %h+%hi r2 %h+%hi cplx %b st %0d",
                                 $time, got.root1_real, got.root1_imag, got.root2_real,
                                 got.root2_imag, got.roots_complex, got.status);
                        o_fail_cnt <= o_fail_cnt + 1;
                    end
                end
            end
        end
    end

    initial o_fail_cnt = 0;

endmodule

// ----- sim/tb.sv -----
// Testbench top for the quadratic root solver: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb;
    import qrs_pkg::*;

    localparam int LATENCY = 71;

    logic i_clk;
    logic i_rst_n;
    int   fail_cnt;
    int   pending;
    int   hold_cycles;
    bit   hold_done;

    qrs_in_if  coef_if ();
    qrs_out_if root_if ();

    quadratic_root_solver_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_coef  (coef_if.sink),
        .o_root  (root_if.source)
    );

    qrs_tb_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_coef     (coef_if.sink),
        .i_root     (root_if.sink),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Coefficients biased toward small values and the extremes.
    function automatic logic [COEF_W-1:0] rand_coef();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return (COEF_W)'($urandom_range(0, 3) == 0 ? 16'h8000 : 16'h7fff);
        if (pick < 4) return (COEF_W)'(int'($urandom_range(0, 1023)) - 512);
        return (COEF_W)'($urandom);
    endfunction

    // Valid stays high between words unless a gap is taken.
    task automatic send_word(logic [COEF_W-1:0] a, logic [COEF_W-1:0] b,
                             logic [COEF_W-1:0] c, bit with_gap);
        int n;
        if (with_gap) begin
            n = gap_len();
            if (n > 0) begin
                coef_if.valid <= 1'b0;
                repeat (n) @(negedge i_clk);
            end
        end
        coef_if.valid  <= 1'b1;
        coef_if.coef_a <= a;
        coef_if.coef_b <= b;
        coef_if.coef_c <= c;
        @(posedge i_clk);
        while (!coef_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Receiver: random stalls, one long hold-off while the sender keeps going.
    initial begin
        int n;
        root_if.ready = 1'b0;
        hold_done = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (!hold_done && hold_cycles == 1) begin
                root_if.ready <= 1'b0;
                repeat (300) @(negedge i_clk);
                hold_done = 1'b1;
            end
            root_if.ready <= ($urandom_range(0, 3) != 0);
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
            repeat (n) @(negedge i_clk);
        end
    end

    initial begin
        int waited;
        coef_if.valid  = 1'b0;
        coef_if.coef_a = '0;
        coef_if.coef_b = '0;
        coef_if.coef_c = '0;
        hold_cycles = 0;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        // Directed: a zero, extremes, real, double and complex roots, saturation.
        send_word(16'h0000, 16'h1234, 16'h5678, 0);
        send_word(16'h0000, 16'h8000, 16'h7fff, 0);
        send_word(16'h0100, 16'hfd00, 16'h0200, 0);
        send_word(16'h0100, 16'hfe00, 16'h0100, 0);
        send_word(16'h0100, 16'h0000, 16'h0100, 0);
        send_word(16'hff00, 16'h0200, 16'hfb00, 0);
        send_word(16'h0001, 16'h7fff, 16'h0000, 0);
        send_word(16'h0001, 16'h8000, 16'h8000, 0);
        send_word(16'h0001, 16'h0000, 16'h7fff, 0);
        send_word(16'hffff, 16'h0000, 16'h7fff, 0);
        send_word(16'h7fff, 16'h7fff, 16'h7fff, 0);
        send_word(16'h8000, 16'h8000, 16'h8000, 0);
        send_word(16'h8000, 16'h7fff, 16'h7fff, 0);
        send_word(16'h7fff, 16'h0001, 16'h8000, 0);
        send_word(16'hffff, 16'hffff, 16'hffff, 0);
        send_word(16'h0001, 16'h0001, 16'h0001, 0);
        send_word(16'h0002, 16'h0000, 16'h0000, 0);
        send_word(16'h5555, 16'haaaa, 16'h5555, 0);
        send_word(16'haaaa, 16'h5555, 16'haaaa, 0);
        hold_cycles = 1;
        // Back to back during the long hold-off so the pipe fills and stalls.
        repeat (120) send_word(rand_coef(), rand_coef(), rand_coef(), 0);
        hold_cycles = 2;
        repeat (580) send_word(rand_coef(), rand_coef(), rand_coef(), 1);
        coef_if.valid <= 1'b0;
        waited = 0;
        while (pending != 0 && waited < 100000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (LATENCY + 20) @(posedge i_clk);
        if (fail_cnt == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("FAILURE");
        $finish;
    end
endmodule

// ----- filelist.f -----
hw/rtl/qrs_pkg.sv
hw/rtl/qrs_in_if.sv
hw/rtl/qrs_out_if.sv
hw/rtl/quadratic_root_solver_unit.sv
hw/rtl/qrs_checker.sv
sim/qrs_checker.sv
sim/tb.sv
